// ===== hdl/rmd128_pkg.sv =====
package rmd128_pkg;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [3:0] widx_t;
  typedef logic [4:0] rot_t;

  // Word selection and rotation for one step, left or right lane.
  function automatic widx_t sel_word(input logic right, input logic [5:0] step);
    logic [3:0] l [64];
    logic [3:0] r [64];
    l = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11,
          4'd12, 4'd13, 4'd14, 4'd15,
          4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3, 4'd12, 4'd0, 4'd9, 4'd5,
          4'd2, 4'd14, 4'd11, 4'd8,
          4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1, 4'd2, 4'd7, 4'd0, 4'd6,
          4'd13, 4'd11, 4'd5, 4'd12,
          4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4, 4'd13, 4'd3, 4'd7, 4'd15,
          4'd14, 4'd5, 4'd6, 4'd2};
    r = '{4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4, 4'd13, 4'd6, 4'd15, 4'd8,
          4'd1, 4'd10, 4'd3, 4'd12,
          4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10, 4'd14, 4'd15, 4'd8, 4'd12,
          4'd4, 4'd9, 4'd1, 4'd2,
          4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9, 4'd11, 4'd8, 4'd12, 4'd2,
          4'd10, 4'd0, 4'd4, 4'd13,
          4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0, 4'd5, 4'd12, 4'd2, 4'd13,
          4'd9, 4'd7, 4'd10, 4'd14};
    return right ? r[step] : l[step];
  endfunction

  function automatic rot_t rot_amt(input logic right, input logic [5:0] step);
    logic [4:0] l [64];
    logic [4:0] r [64];
    l = '{5'd11, 5'd14, 5'd15, 5'd12, 5'd5, 5'd8, 5'd7, 5'd9, 5'd11, 5'd13, 5'd14, 5'd15,
          5'd6, 5'd7, 5'd9, 5'd8,
          5'd7, 5'd6, 5'd8, 5'd13, 5'd11, 5'd9, 5'd7, 5'd15, 5'd7, 5'd12, 5'd15, 5'd9,
          5'd11, 5'd7, 5'd13, 5'd12,
          5'd11, 5'd13, 5'd6, 5'd7, 5'd14, 5'd9, 5'd13, 5'd15, 5'd14, 5'd8, 5'd13, 5'd6,
          5'd5, 5'd12, 5'd7, 5'd5,
          5'd11, 5'd12, 5'd14, 5'd15, 5'd14, 5'd15, 5'd9, 5'd8, 5'd9, 5'd14, 5'd5, 5'd6,
          5'd8, 5'd6, 5'd5, 5'd12};
    r = '{5'd8, 5'd9, 5'd9, 5'd11, 5'd13, 5'd15, 5'd15, 5'd5, 5'd7, 5'd7, 5'd8, 5'd11,
          5'd14, 5'd14, 5'd12, 5'd6,
          5'd9, 5'd13, 5'd15, 5'd7, 5'd12, 5'd8, 5'd9, 5'd11, 5'd7, 5'd7, 5'd12, 5'd7,
          5'd6, 5'd15, 5'd13, 5'd11,
          5'd9, 5'd7, 5'd15, 5'd11, 5'd8, 5'd6, 5'd6, 5'd14, 5'd12, 5'd13, 5'd5, 5'd14,
          5'd13, 5'd13, 5'd7, 5'd5,
          5'd15, 5'd5, 5'd8, 5'd11, 5'd14, 5'd14, 5'd6, 5'd14, 5'd6, 5'd9, 5'd12, 5'd9,
          5'd12, 5'd5, 5'd15, 5'd8};
    return right ? r[step] : l[step];
  endfunction

  function automatic logic [31:0] round_k(input logic right, input logic [1:0] rnd);
    logic [31:0] k;
    if (right) begin
      unique case (rnd)
        2'd0: k = 32'h50A28BE6;
        2'd1: k = 32'h5C4DD124;
        2'd2: k = 32'h6D703EF3;
        default: k = 32'h00000000;
      endcase
    end else begin
      unique case (rnd)
        2'd0: k = 32'h00000000;
        2'd1: k = 32'h5A827999;
        2'd2: k = 32'h6ED9EBA1;
        default: k = 32'h8F1BBCDC;
      endcase
    end
    return k;
  endfunction

  typedef struct packed {
    logic        right;
    logic [5:0]  step;
  } step_ctl_t;

endpackage

// ===== hdl/rmd128_step.sv =====
// One RIPEMD-128 step, shared by both lanes and all 64 steps.
module rmd128_step (
  input  rmd128_pkg::step_ctl_t ctl,
  input  logic [31:0]           a,
  input  logic [31:0]           b,
  input  logic [31:0]           c,
  input  logic [31:0]           d,
  input  logic [31:0]           x,
  output logic [31:0]           t
);
  logic [1:0]  rnd;
  logic [1:0]  fn;
  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  s;

  always_comb begin
    rnd = ctl.step[5:4];
    fn  = ctl.right ? (2'd3 - rnd) : rnd;
    unique case (fn)
      2'd0: f = b ^ c ^ d;
      2'd1: f = d ^ (b & (c ^ d));
      2'd2: f = (b | ~c) ^ d;
      default: f = c ^ (d & (b ^ c));
    endcase
    sum = a + f + x + rmd128_pkg::round_k(ctl.right, rnd);
    s   = rmd128_pkg::rot_amt(ctl.right, ctl.step);
    t   = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end
endmodule

// ===== hdl/ripemd128_hash.sv =====
// A byte that does not fill a block is taken straight into the block buffer.
// A full block runs 64 left-lane steps, then 64 right-lane steps on the single
// shared step unit, then a combine state. A close runs one or two padded blocks and then
// shows four digest beats, one per cycle while the output side is ready.
// Reset (rst, synchronous, active high) loads the standard chaining values, clears the
// block buffer and byte count, and drops any pending digest.
module ripemd128_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // byte_valid
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [33:32] word_index, zero pad
  output logic        m_tlast    // last_word
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LANE  = 6'b000010,
    S_COMB  = 6'b000100,
    S_PAD   = 6'b001000,
    S_LEN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t      state;
  logic [31:0] h [4];
  logic [31:0] blk [16];
  logic [63:0] count;
  logic [31:0] va, vb, vc, vd;   // working lane registers
  logic [31:0] l0, l1, l2, l3;   // saved left-lane result
  rmd128_pkg::step_ctl_t ctl;
  logic        closing;          // padding follows this compression
  logic        len_pending;      // the length block still has to run
  logic [1:0]  oidx;
  logic [31:0] t;
  // The compression that follows the length block produces the digest.
  logic        final_run;

  rmd128_step u_step (
    .ctl(ctl), .a(va), .b(vb), .c(vc), .d(vd),
    .x(blk[rmd128_pkg::sel_word(ctl.right, ctl.step)]), .t(t)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {6'd0, oidx, h[oidx]};
  assign m_tlast  = (oidx == 2'd3);

  logic [5:0] pos;
  assign pos = count[5:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      h[0] <= rmd128_pkg::H0; h[1] <= rmd128_pkg::H1;
      h[2] <= rmd128_pkg::H2; h[3] <= rmd128_pkg::H3;
      for (int i = 0; i < 16; i++) blk[i] <= '0;
      count <= '0;
      ctl <= '0;
      closing <= 1'b0;
      len_pending <= 1'b0;
      oidx <= '0;
      final_run <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) begin
              blk[pos[5:2]][8*pos[1:0] +: 8] <= s_tdata;
              count <= count + 64'd1;
            end
            closing <= s_tlast;
            if (s_tuser && pos == 6'd63) begin
              state <= S_LANE;
              ctl <= '0;
              va <= h[0]; vb <= h[1]; vc <= h[2]; vd <= h[3];
            end else if (s_tlast) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // Marker byte; the rest of the block is already zero.
          blk[pos[5:2]][8*pos[1:0] +: 8] <= rmd128_pkg::PAD_BYTE;
          closing <= 1'b0;
          if (pos >= 6'd56) begin
            len_pending <= 1'b1;
            state <= S_LANE;
            ctl <= '0;
            va <= h[0]; vb <= h[1]; vc <= h[2]; vd <= h[3];
          end else begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          blk[14] <= {count[28:0], 3'd0};
          blk[15] <= count[60:29];
          len_pending <= 1'b0;
          state <= S_LANE;
          ctl <= '0;
          va <= h[0]; vb <= h[1]; vc <= h[2]; vd <= h[3];
        end
        S_LANE: begin
          va <= vd; vd <= vc; vc <= vb; vb <= t;
          if (ctl.step == 6'd63) begin
            if (!ctl.right) begin
              l0 <= vd; l1 <= t; l2 <= vb; l3 <= vc;
              va <= h[0]; vb <= h[1]; vc <= h[2]; vd <= h[3];
              ctl <= '{right: 1'b1, step: 6'd0};
            end else begin
              state <= S_COMB;
            end
          end else begin
            ctl.step <= ctl.step + 6'd1;
          end
        end
        S_COMB: begin
          // va..vd now hold the right-lane result r0..r3.
          h[0] <= h[1] + l2 + vd;
          h[1] <= h[2] + l3 + va;
          h[2] <= h[3] + l0 + vb;
          h[3] <= h[0] + l1 + vc;
          for (int i = 0; i < 16; i++) blk[i] <= '0;
          if (closing) state <= S_PAD;
          else if (len_pending) state <= S_LEN;
          else if (oidx == 2'd0 && final_run) state <= S_OUT;
          else state <= S_IDLE;
        end
        S_OUT: begin
          if (m_tready) begin
            oidx <= oidx + 2'd1;
            if (oidx == 2'd3) begin
              state <= S_IDLE;
              h[0] <= rmd128_pkg::H0; h[1] <= rmd128_pkg::H1;
              h[2] <= rmd128_pkg::H2; h[3] <= rmd128_pkg::H3;
              count <= '0;
              final_run <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_LEN) final_run <= 1'b1;
    end
  end
endmodule

// ===== hdl/rmd128_check.sv =====
module rmd128_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);
  a_excl: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input ready while digest is shown");
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[33:32] == 2'd3)))
    else $error("last flag does not match word index");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && m_tdata[33:32] == $past(m_tdata[33:32]) + 2'd1))
    else $error("digest words out of order");
  a_after: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
    else $error("block not idle after digest");
endmodule

bind ripemd128_hash rmd128_check u_check (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

// ===== dv/tb_ripemd128_hash.sv =====
`timescale 1ns / 1ps

module tb_ripemd128_hash;

  // Digest words come out as tdata {pad, word_index, digest_word} with tlast marking word 3.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } byte_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  localparam int MAX_REPORTS = 10;

  localparam logic [3:0] LSEL [64] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
    7, 4, 13, 1, 10, 6, 15, 3, 12, 0, 9, 5, 2, 14, 11, 8,
    3, 10, 14, 4, 9, 15, 8, 1, 2, 7, 0, 6, 13, 11, 5, 12,
    1, 9, 11, 10, 0, 8, 12, 4, 13, 3, 7, 15, 14, 5, 6, 2};
  localparam logic [4:0] LROT [64] = '{
    11, 14, 15, 12, 5, 8, 7, 9, 11, 13, 14, 15, 6, 7, 9, 8,
    7, 6, 8, 13, 11, 9, 7, 15, 7, 12, 15, 9, 11, 7, 13, 12,
    11, 13, 6, 7, 14, 9, 13, 15, 14, 8, 13, 6, 5, 12, 7, 5,
    11, 12, 14, 15, 14, 15, 9, 8, 9, 14, 5, 6, 8, 6, 5, 12};
  localparam logic [3:0] RSEL [64] = '{
    5, 14, 7, 0, 9, 2, 11, 4, 13, 6, 15, 8, 1, 10, 3, 12,
    6, 11, 3, 7, 0, 13, 5, 10, 14, 15, 8, 12, 4, 9, 1, 2,
    15, 5, 1, 3, 7, 14, 6, 9, 11, 8, 12, 2, 10, 0, 4, 13,
    8, 6, 4, 1, 3, 11, 15, 0, 5, 12, 2, 13, 9, 7, 10, 14};
  localparam logic [4:0] RROT [64] = '{
    8, 9, 9, 11, 13, 15, 15, 5, 7, 7, 8, 11, 14, 14, 12, 6,
    9, 13, 15, 7, 12, 8, 9, 11, 7, 7, 12, 7, 6, 15, 13, 11,
    9, 7, 15, 11, 8, 6, 6, 14, 12, 13, 5, 14, 13, 13, 7, 5,
    15, 5, 8, 11, 14, 14, 6, 14, 6, 9, 12, 9, 12, 5, 15, 8};
  localparam logic [31:0] LK [4] = '{32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC};
  localparam logic [31:0] RK [4] = '{32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h00000000};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  ripemd128_hash u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: chaining words, message block and byte count.
  logic [31:0] chain [4];
  logic [31:0] blk [16];
  logic [63:0] msg_bytes;

  byte_beat_t   pending_bytes [$];
  digest_beat_t expected_digest [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  int mismatches = 0;
  int digests_checked = 0;
  int messages_closed = 0;
  bit last_accept = 1'b0;

  function automatic logic [31:0] rmd_fn(int fn, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z);
    case (fn)
      0: return x ^ y ^ z;
      1: return z ^ (x & (y ^ z));
      2: return (x | ~y) ^ z;
      default: return y ^ (z & (x ^ y));
    endcase
  endfunction

  function automatic logic [31:0] rotl32(logic [31:0] x, logic [4:0] s);
    return (x << s) | (x >> (6'd32 - s));
  endfunction

  // One compression: both lanes over the block, then the cross-combination.
  task automatic compress_block();
    logic [31:0] l [4];
    logic [31:0] r [4];
    logic [31:0] t;
    int rnd;
    for (int k = 0; k < 4; k++) begin
      l[k] = chain[k];
      r[k] = chain[k];
    end
    for (int i = 0; i < 64; i++) begin
      rnd = i / 16;
      t = rotl32(l[0] + rmd_fn(rnd, l[1], l[2], l[3]) + blk[LSEL[i]] + LK[rnd], LROT[i]);
      l[0] = l[3]; l[3] = l[2]; l[2] = l[1]; l[1] = t;
      t = rotl32(r[0] + rmd_fn(3 - rnd, r[1], r[2], r[3]) + blk[RSEL[i]] + RK[rnd],
                 RROT[i]);
      r[0] = r[3]; r[3] = r[2]; r[2] = r[1]; r[1] = t;
    end
    t = chain[1] + l[2] + r[3];
    chain[1] = chain[2] + l[3] + r[0];
    chain[2] = chain[3] + l[0] + r[1];
    chain[3] = chain[0] + l[1] + r[2];
    chain[0] = t;
    for (int k = 0; k < 16; k++) blk[k] = '0;
  endtask

  task automatic clear_digest_state();
    chain[0] = 32'h67452301; chain[1] = 32'hEFCDAB89;
    chain[2] = 32'h98BADCFE; chain[3] = 32'h10325476;
    for (int k = 0; k < 16; k++) blk[k] = '0;
    msg_bytes = '0;
  endtask

  task automatic place_byte(int pos, logic [7:0] b);
    blk[pos / 4][8 * (pos % 4) +: 8] = b;
  endtask

  // Advance the predictor by one accepted beat and queue any digest words it causes.
  task automatic predict_digest(byte_beat_t bt);
    int pos;
    logic [63:0] bits;
    digest_beat_t d;
    if (bt.byte_valid) begin
      pos = int'(msg_bytes[5:0]);
      place_byte(pos, bt.data_byte);
      msg_bytes++;
      if (pos == 63) compress_block();
    end
    if (bt.end_of_message) begin
      pos = int'(msg_bytes[5:0]);
      bits = msg_bytes << 3;
      place_byte(pos, 8'h80);
      for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
      if (pos >= 56) compress_block();
      blk[14] = bits[31:0];
      blk[15] = bits[63:32];
      compress_block();
      for (int i = 0; i < 4; i++) begin
        d.digest_word = chain[i];
        d.word_index = 2'(i);
        d.last_word = (i == 3);
        expected_digest.push_back(d);
      end
      messages_closed++;
      clear_digest_state();
    end
  endtask

  initial clear_digest_state();

  // Driver: presents the head of the byte queue, idling at the current rate.
  // A beat stays on the bus until the edge that accepts it.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || last_accept) begin
      if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        {s_tdata, s_tuser, s_tlast} <= pending_bytes[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // The accepted beat leaves the queue at the edge where the handshake happens.
  always @(posedge clk) begin
    last_accept = !rst && s_tvalid && s_tready;
    if (last_accept) begin
      predict_digest(pending_bytes.pop_front());
    end
  end

  // The long hold-off is counted down here, separate from the random stall.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each digest beat against the oldest expectation.
  always @(posedge clk) begin
    digest_beat_t got;
    digest_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.digest_word = m_tdata[31:0];
      got.word_index = m_tdata[33:32];
      got.last_word = m_tlast;
      if (expected_digest.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected digest beat word=%h idx=%0d last=%0b",
                   got.digest_word, got.word_index, got.last_word);
      end else begin
        want = expected_digest.pop_front();
        digests_checked++;
        if (got !== want || m_tdata[39:34] !== 6'd0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: digest beat exp word=%h idx=%0d last=%0b got word=%h idx=%0d last=%0b pad=%h",
                     want.digest_word, want.word_index, want.last_word,
                     got.digest_word, got.word_index, got.last_word, m_tdata[39:34]);
        end
      end
    end
  end

  task automatic queue_beat(logic [7:0] b, logic v, logic e);
    byte_beat_t bt;
    bt.data_byte = b;
    bt.byte_valid = v;
    bt.end_of_message = e;
    pending_bytes.push_back(bt);
  endtask

  // A message of n random bytes; the close is either on the last byte or an empty beat.
  task automatic queue_message(int n);
    bit close_on_byte;
    close_on_byte = (n > 0) && $urandom_range(1);
    for (int i = 0; i < n; i++) begin
      // Occasional beats with no message byte are noise the block must ignore.
      if ($urandom_range(9) == 0) queue_beat(8'($urandom), 1'b0, 1'b0);
      queue_beat(8'($urandom), 1'b1, close_on_byte && (i == n - 1));
    end
    if (!close_on_byte) queue_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    while (pending_bytes.size() > 0 || expected_digest.size() > 0) @(posedge clk);
  endtask

  int phase_pct [4][2] = '{'{0, 0}, '{75, 0}, '{0, 75}, '{26, 26}};
  int lens [6] = '{0, 1, 55, 56, 63, 64};
  int len;

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty message, a close with a byte, extreme bytes and the padding
    // boundaries at 55, 56, 63 and 64 bytes.
    queue_beat(8'h00, 1'b0, 1'b1);
    queue_beat(8'hFF, 1'b1, 1'b1);
    queue_beat(8'h00, 1'b1, 1'b0);
    queue_beat(8'hA5, 1'b0, 1'b0);
    queue_beat(8'h5A, 1'b1, 1'b1);
    foreach (lens[i]) queue_message(lens[i]);
    drain();

    // Pressure: the receiver holds off long while the sender keeps offering short
    // messages, so digests back up and the input stalls.
    hold_off_cycles = 3000;
    for (int i = 0; i < 8; i++) queue_message($urandom_range(3));
    drain();

    // Random phases over the idling mixes, with a full pause between phases.
    foreach (phase_pct[p]) begin
      send_idle_pct = phase_pct[p][0];
      recv_stall_pct = phase_pct[p][1];
      for (int m = 0; m < 3; m++) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(130) : $urandom_range(12);
        queue_message(len);
      end
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);

    $display("Checked %0d digest words from %0d messages across four idling mixes,",
             digests_checked, messages_closed);
    $display("including padding boundaries, empty messages and a long output stall.");
    if (mismatches == 0 && expected_digest.size() == 0) begin
      $display("ripemd128_hash test passed");
    end else begin
      $display("ripemd128_hash test failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("ripemd128_hash test failed");
    $finish;
  end

endmodule
